[src/rtnh_pkg.sv]
// Shared widths, codes and types of the nearest ray-triangle hit block.
`default_nettype none
package rtnh_pkg;

  localparam int unsigned MAX_TRIANGLES_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ACC_W       = 104;

  localparam logic [DIST_W-1:0] INFINITY = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    GRP_H   = 3'd0,
    GRP_Q   = 3'd1,
    GRP_DET = 3'd2,
    GRP_NU  = 3'd3,
    GRP_NV  = 3'd4,
    GRP_NT  = 3'd5
  } mul_grp_t;

  typedef enum logic [1:0] {
    SEL_T  = 2'd0,
    SEL_W0 = 2'd1,
    SEL_W1 = 2'd2,
    SEL_W2 = 2'd3
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_NORM,
    ST_CLASS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] origin;
    logic [2:0][COORD_W-1:0] dir;
  } ray_cfg_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] e1;
    logic [2:0][DIFF_W-1:0] e2;
    logic [2:0][DIFF_W-1:0] s;
    logic [IDX_W-1:0]       index;
    logic                   active;
    logic                   last;
  } tri_entry_t;

endpackage
`default_nettype wire

[src/rtnh_front.sv]
// Front end: takes triangle beats, forms edge and origin vectors, numbers them.
`default_nettype none
module rtnh_front import rtnh_pkg::*; #(
  parameter int unsigned MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ray_cfg_t                  cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      last_tri,
  input  logic                      full,
  output logic                      push,
  output tri_entry_t                entry
);

  localparam int unsigned IDX_SPAN = 1 << IDX_W;
  localparam int unsigned LIMIT = (MAX_TRIANGLES < IDX_SPAN) ? MAX_TRIANGLES : IDX_SPAN;
  localparam int unsigned CNT_W = $clog2(LIMIT + 1);

  logic [CNT_W-1:0] tri_count;
  logic             active;

  function automatic logic [DIFF_W-1:0] diff(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    return {x[COORD_W-1], x} - {y[COORD_W-1], y};
  endfunction

  assign active   = tri_count < CNT_W'(LIMIT);
  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    entry.e1[0] = diff(b_x, a_x);
    entry.e1[1] = diff(b_y, a_y);
    entry.e1[2] = diff(b_z, a_z);
    entry.e2[0] = diff(c_x, a_x);
    entry.e2[1] = diff(c_y, a_y);
    entry.e2[2] = diff(c_z, a_z);
    entry.s[0]  = diff(cfg.origin[0], a_x);
    entry.s[1]  = diff(cfg.origin[1], a_y);
    entry.s[2]  = diff(cfg.origin[2], a_z);
    entry.index  = IDX_W'(tri_count);
    entry.active = active;
    entry.last   = last_tri;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_count <= '0;
    end else if (push) begin
      if (last_tri) begin
        tri_count <= '0;
      end else if (active) begin
        tri_count <= tri_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/rtnh_fifo.sv]
// Short queue of prepared triangles between the front and the back end.
`default_nettype none
module rtnh_fifo import rtnh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tri_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output tri_entry_t rd_entry,
  output logic       empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  tri_entry_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/rtnh_div.sv]
// Restoring divider giving floor(num * 2^FRAC_BITS / den), one bit per cycle, saturating.
`default_nettype none
module rtnh_div import rtnh_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              wide_q,
  input  logic [ACC_W-1:0]  num,
  input  logic [ACC_W-1:0]  den,
  output logic              done,
  output logic [DIST_W-1:0] quot
);

  localparam int unsigned DW    = ACC_W + DIST_W + 1;
  localparam int unsigned CNT_W = $clog2(DIST_W + 1);
  localparam logic [DIST_W-1:0] WEIGHT_SAT = DIST_W'({WEIGHT_W{1'b1}});

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             first;
  logic             wide_r;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= DW'(num) << FRAC_BITS;
      dsh    <= wide_q ? (DW'(den) << DIST_W) : (DW'(den) << WEIGHT_W);
      cnt    <= wide_q ? CNT_W'(DIST_W - 1) : CNT_W'(WEIGHT_W - 1);
      quot   <= '0;
      first  <= 1'b1;
      wide_r <= wide_q;
    end else if (busy) begin
      first <= 1'b0;
      dsh   <= dsh >> 1;
      if (first) begin
        if (ge) begin
          quot <= wide_r ? INFINITY : WEIGHT_SAT;
        end
      end else begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[DIST_W-2:0], ge};
        cnt  <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if ((first && ge) || (!first && cnt == '0)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/rtnh_back.sv]
// Back end: Cramer solve on one shared multiplier, hit test, divisions, nearest-hit record.
`default_nettype none
module rtnh_back import rtnh_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ray_cfg_t            cfg,
  input  logic                empty,
  input  tri_entry_t          entry,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                hit,
  output logic [IDX_W-1:0]    nearest_index,
  output logic [DIST_W-1:0]   distance,
  output logic [WEIGHT_W-1:0] weight_a,
  output logic [WEIGHT_W-1:0] weight_b,
  output logic [WEIGHT_W-1:0] weight_c
);

  localparam int unsigned MUL_W  = DIFF_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned HQ_W   = 2 * DIFF_W + 1;

  back_state_t state, state_next;

  mul_grp_t               grp;
  logic [2:0]             sub;
  logic [2:0][DIFF_W-1:0] e1, e2, s;
  logic [IDX_W-1:0]       index_r;
  logic                   last_r;
  logic [2:0][HQ_W-1:0]   h, q;
  logic [ACC_W-1:0]       det, nu, nv, nt, nw, acc;
  logic [PROD_W-1:0]      prod;
  logic                   p_vld, p_first, p_done, p_hi, p_neg;
  mul_grp_t               p_grp;
  logic [1:0]             p_k;
  div_sel_t               sel;

  logic                     any_hit;
  logic [DIST_W-1:0]        best_distance;
  logic [IDX_W-1:0]         best_index;
  logic [2:0][WEIGHT_W-1:0] best_w;

  logic [1:0]        k, i1, i2, ai, bi;
  logic              m_first, m_done, m_hi, m_neg;
  logic [MUL_W-1:0]  a_op, b_op;
  logic [HQ_W-1:0]   hv;
  logic [ACC_W-1:0]  ext, shifted, term, acc_sum, nw_c;
  logic              hit_ok, better, room;
  logic              issue, div_start, div_done, emit;
  logic [DIST_W-1:0] quot;
  logic [ACC_W-1:0]  div_num;

  // Operation decode for the current multiplier slot.
  always_comb begin
    k = sub[2:1];
    unique case (k)
      2'd0: begin
        i1 = 2'd1;
        i2 = 2'd2;
      end
      2'd1: begin
        i1 = 2'd2;
        i2 = 2'd0;
      end
      default: begin
        i1 = 2'd0;
        i2 = 2'd1;
      end
    endcase
    if (grp == GRP_H || grp == GRP_Q) begin
      ai      = sub[0] ? i2 : i1;
      bi      = sub[0] ? i1 : i2;
      m_neg   = sub[0];
      m_first = !sub[0];
      m_done  = sub[0];
      m_hi    = 1'b0;
    end else begin
      ai      = k;
      bi      = k;
      m_neg   = 1'b0;
      m_first = sub == 3'd0;
      m_done  = sub == 3'd5;
      m_hi    = sub[0];
    end
  end

  always_comb begin
    a_op = '0;
    b_op = '0;
    hv   = '0;
    unique case (grp) inside
      GRP_H, GRP_NV: a_op = {{(MUL_W - COORD_W){cfg.dir[ai][COORD_W-1]}}, cfg.dir[ai]};
      GRP_Q, GRP_NU: a_op = {s[ai][DIFF_W-1], s[ai]};
      GRP_DET:       a_op = {e1[ai][DIFF_W-1], e1[ai]};
      default:       a_op = {e2[ai][DIFF_W-1], e2[ai]};
    endcase
    unique case (grp) inside
      GRP_H:           b_op = {e2[bi][DIFF_W-1], e2[bi]};
      GRP_Q:           b_op = {e1[bi][DIFF_W-1], e1[bi]};
      GRP_DET, GRP_NU: hv = h[bi];
      default:         hv = q[bi];
    endcase
    if (grp != GRP_H && grp != GRP_Q) begin
      b_op = m_hi ? hv[HQ_W-1:DIFF_W] : {1'b0, hv[DIFF_W-1:0]};
    end
  end

  always_comb begin
    ext     = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    shifted = p_hi ? (ext << DIFF_W) : ext;
    term    = p_neg ? ('0 - shifted) : shifted;
    acc_sum = (p_first ? '0 : acc) + term;
  end

  assign nw_c   = det - nu - nv;
  assign hit_ok = !nu[ACC_W-1] && !nv[ACC_W-1] && !nt[ACC_W-1] && !nw_c[ACC_W-1];
  assign better = !any_hit || (quot < best_distance);
  assign room   = !out_valid || out_ready;

  always_comb begin
    unique case (sel)
      SEL_T:   div_num = nt;
      SEL_W0:  div_num = nw;
      SEL_W1:  div_num = nu;
      default: div_num = nv;
    endcase
  end

  rtnh_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .wide_q(sel == SEL_T),
    .num   (div_num),
    .den   (det),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = entry.active ? ST_MUL : ST_FINISH;
        end
      end
      ST_MUL: begin
        if (grp == GRP_NT && sub == 3'd5) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_NORM;
      ST_NORM: state_next = (det == '0) ? ST_FINISH : ST_CLASS;
      ST_CLASS: state_next = hit_ok ? ST_DIV_GO : ST_FINISH;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel)
            SEL_T:   state_next = better ? ST_DIV_GO : ST_FINISH;
            SEL_W2:  state_next = ST_FINISH;
            default: state_next = ST_DIV_GO;
          endcase
        end
      end
      default: begin
        if (!last_r || room) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state)
      ST_IDLE:   pop = !empty;
      ST_MUL:    issue = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_FINISH: emit = last_r && room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e1      <= entry.e1;
      e2      <= entry.e2;
      s       <= entry.s;
      index_r <= entry.index;
      last_r  <= entry.last;
      grp     <= GRP_H;
      sub     <= 3'd0;
    end
    if (issue) begin
      prod    <= $signed(a_op) * $signed(b_op);
      p_first <= m_first;
      p_done  <= m_done;
      p_hi    <= m_hi;
      p_neg   <= m_neg;
      p_grp   <= grp;
      p_k     <= k;
      if (sub == 3'd5) begin
        sub <= 3'd0;
        grp <= mul_grp_t'(grp + 1'b1);
      end else begin
        sub <= sub + 1'b1;
      end
    end
    if (p_vld) begin
      acc <= acc_sum;
      if (p_done) begin
        unique case (p_grp)
          GRP_H:   h[p_k] <= acc_sum[HQ_W-1:0];
          GRP_Q:   q[p_k] <= acc_sum[HQ_W-1:0];
          GRP_DET: det <= acc_sum;
          GRP_NU:  nu <= acc_sum;
          GRP_NV:  nv <= acc_sum;
          default: nt <= acc_sum;
        endcase
      end
    end
    if (state == ST_NORM) begin
      sel <= SEL_T;
      if (det[ACC_W-1]) begin
        det <= '0 - det;
        nu  <= '0 - nu;
        nv  <= '0 - nv;
        nt  <= '0 - nt;
      end
    end
    if (state == ST_CLASS) begin
      nw <= nw_c;
    end
    if (state == ST_DIV_WAIT && div_done && sel != SEL_W2) begin
      sel <= div_sel_t'(sel + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit       <= 1'b0;
      best_distance <= INFINITY;
      best_index    <= '0;
      best_w        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DIV_WAIT && div_done) begin
        unique case (sel)
          SEL_T: begin
            if (better) begin
              any_hit       <= 1'b1;
              best_distance <= quot;
              best_index    <= index_r;
            end
          end
          SEL_W0:  best_w[0] <= quot[WEIGHT_W-1:0];
          SEL_W1:  best_w[1] <= quot[WEIGHT_W-1:0];
          default: best_w[2] <= quot[WEIGHT_W-1:0];
        endcase
      end
      if (emit) begin
        out_valid     <= 1'b1;
        any_hit       <= 1'b0;
        best_distance <= INFINITY;
        best_index    <= '0;
        best_w        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit           <= any_hit;
      nearest_index <= best_index;
      distance      <= best_distance;
      weight_a      <= best_w[0];
      weight_b      <= best_w[1];
      weight_c      <= best_w[2];
    end
  end

endmodule
`default_nettype wire

[src/ray_triangle_nearest_hit.sv]
// Top level of the nearest ray-triangle hit search.
//
// Usage: write the ray origin and direction on the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) while the block is idle; cfg_ready
// is always high. Then stream triangles on the input channel, one per beat,
// with last_tri set on the final triangle of the scene. Only that beat
// produces a result beat on the output channel: hit flag, index of the nearest
// hit, its distance t (unsigned Q15.16) and three barycentric weights (unsigned Q1.16).
// In the back end a triangle takes 36 products on one shared 34x34 multiplier;
// a singular system or a failed hit test ends it there. Otherwise a divider
// retiring one quotient bit per cycle finds t (31 bits) and, for a new nearest
// hit, each of the three weights (17 bits each). A saturated t ends its division
// at the first step. A triangle past the index limit skips the back end's work.
// A two-entry queue lets the front take triangles while the back end works.
// Reset restores the default ray (origin zero, direction minus z) and clears
// the search state. When the receiver stalls, the result is held in the output
// register; further triangles keep flowing until the next last beat must wait.
`default_nettype none
module ray_triangle_nearest_hit import rtnh_pkg::*; #(
  parameter int unsigned MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      last_tri,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic [IDX_W-1:0]          nearest_index,
  output logic [DIST_W-1:0]         distance,
  output logic [WEIGHT_W-1:0]       weight_a,
  output logic [WEIGHT_W-1:0]       weight_b,
  output logic [WEIGHT_W-1:0]       weight_c
);

  ray_cfg_t   cfg;
  tri_entry_t wr_entry, rd_entry;
  logic       push, full, pop, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin <= '0;
      cfg.dir[0] <= '0;
      cfg.dir[1] <= '0;
      cfg.dir[2] <= 32'hFFFF_0000;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X: cfg.origin[0] <= cfg_data;
        CFG_ORIGIN_Y: cfg.origin[1] <= cfg_data;
        CFG_ORIGIN_Z: cfg.origin[2] <= cfg_data;
        CFG_DIR_X:    cfg.dir[0] <= cfg_data;
        CFG_DIR_Y:    cfg.dir[1] <= cfg_data;
        CFG_DIR_Z:    cfg.dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rtnh_front #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .a_x     (a_x),
    .a_y     (a_y),
    .a_z     (a_z),
    .b_x     (b_x),
    .b_y     (b_y),
    .b_z     (b_z),
    .c_x     (c_x),
    .c_y     (c_y),
    .c_z     (c_z),
    .last_tri(last_tri),
    .full    (full),
    .push    (push),
    .entry   (wr_entry)
  );

  rtnh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .full    (full),
    .pop     (pop),
    .rd_entry(rd_entry),
    .empty   (empty)
  );

  rtnh_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .entry        (rd_entry),
    .pop          (pop),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .hit          (hit),
    .nearest_index(nearest_index),
    .distance     (distance),
    .weight_a     (weight_a),
    .weight_b     (weight_b),
    .weight_c     (weight_c)
  );

endmodule
`default_nettype wire

[src/rtnh_checker.sv]
// Port-level checks of the nearest ray-triangle hit block, bound to its top level.
`default_nettype none
module rtnh_checker import rtnh_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      hit,
  input logic [IDX_W-1:0]          nearest_index,
  input logic [DIST_W-1:0]         distance,
  input logic [WEIGHT_W-1:0]       weight_a,
  input logic [WEIGHT_W-1:0]       weight_b,
  input logic [WEIGHT_W-1:0]       weight_c
);

  localparam int unsigned WSUM_W = WEIGHT_W + 2;

  logic [WSUM_W-1:0] wsum;

  assign wsum = {2'b00, weight_a} + {2'b00, weight_b} + {2'b00, weight_c};

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance)
      && $stable(nearest_index) && $stable(weight_a))
    else $error("stalled result beat changed");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == INFINITY && nearest_index == '0
      && weight_a == '0 && weight_b == '0 && weight_c == '0)
    else $error("miss result carries hit data");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> wsum <= (WSUM_W'(1) << FRAC_BITS))
    else $error("barycentric weights sum above one");

endmodule

bind ray_triangle_nearest_hit rtnh_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
`default_nettype wire

[tb/ray_triangle_nearest_hit_tb.sv]
// Testbench of the nearest ray-triangle hit search: scenes of triangles against a bit-exact predictor.
module ray_triangle_nearest_hit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtnh_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1800;
  localparam int SETTLE      = 300;
  localparam logic signed [31:0] U = 32'sd65536;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] c [3];
    logic               last;
  } tri_t;

  typedef struct {
    logic                hit;
    logic [IDX_W-1:0]    idx;
    logic [DIST_W-1:0]   tval;
    logic [WEIGHT_W-1:0] w [3];
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [COORD_W-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [COORD_W-1:0] c_x = '0, c_y = '0, c_z = '0;
  logic last_tri = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [IDX_W-1:0] nearest_index;
  logic [DIST_W-1:0] distance;
  logic [WEIGHT_W-1:0] weight_a, weight_b, weight_c;

  ray_triangle_nearest_hit i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z), .last_tri(last_tri),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .nearest_index(nearest_index), .distance(distance),
    .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c)
  );

  always #5 clk = ~clk;

  // Shadow of the ray registers and of the search state.
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [DIST_W-1:0]   near_dist;
  logic [IDX_W-1:0]    near_idx;
  logic [WEIGHT_W-1:0] near_w [3];
  int unsigned         tri_seen;
  logic                near_valid;

  hit_rec_t pending_hits[$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int stall_mode = 0;
  int mode_cnt = 0;

  function automatic void clear_search();
    near_dist = INFINITY;
    near_idx = '0;
    for (int k = 0; k < 3; k++) near_w[k] = '0;
    tri_seen = 0;
    near_valid = 1'b0;
  endfunction

  function automatic void cross3(input wide_t u [3], input wide_t v [3], output wide_t r [3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  function automatic wide_t dot3(input wide_t u [3], input wide_t v [3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic logic [31:0] floor_ratio(input wide_t num, input wide_t den,
                                              input logic [31:0] lim);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    n = num;
    d = den;
    n = n << FRAC_BITS_DEF;
    q = n / d;
    if (q > {96'd0, lim}) return lim;
    return q[31:0];
  endfunction

  function automatic void track_triangle(input tri_t tr);
    wide_t e1 [3], e2 [3], s [3], d [3], h [3], q [3];
    wide_t det, nu, nv, nt, nw;
    logic [31:0] t;
    hit_rec_t rec;
    if (tri_seen < 65536) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] = wide_t'(tr.b[k]) - wide_t'(tr.a[k]);
        e2[k] = wide_t'(tr.c[k]) - wide_t'(tr.a[k]);
        s[k]  = wide_t'(ray_org[k]) - wide_t'(tr.a[k]);
        d[k]  = wide_t'(ray_dir[k]);
      end
      cross3(d, e2, h);
      det = dot3(e1, h);
      if (det != 0) begin
        nu = dot3(s, h);
        cross3(s, e1, q);
        nv = dot3(d, q);
        nt = dot3(e2, q);
        if (det < 0) begin
          det = -det;
          nu = -nu;
          nv = -nv;
          nt = -nt;
        end
        nw = det - nu - nv;
        if (nu >= 0 && nv >= 0 && nw >= 0 && nt >= 0) begin
          t = floor_ratio(nt, det, 32'h7FFF_FFFF);
          if (!near_valid || t[30:0] < near_dist) begin
            near_valid = 1'b1;
            near_dist = t[30:0];
            near_idx = tri_seen[15:0];
            near_w[0] = WEIGHT_W'(floor_ratio(nw, det, 32'h1FFFF));
            near_w[1] = WEIGHT_W'(floor_ratio(nu, det, 32'h1FFFF));
            near_w[2] = WEIGHT_W'(floor_ratio(nv, det, 32'h1FFFF));
          end
        end
      end
      tri_seen++;
    end
    if (tr.last) begin
      rec.hit = near_valid;
      rec.idx = near_valid ? near_idx : '0;
      rec.tval = near_valid ? near_dist : INFINITY;
      for (int k = 0; k < 3; k++) rec.w[k] = near_valid ? near_w[k] : '0;
      pending_hits = {pending_hits, rec};
      clear_search();
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    hit_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: result beat with none expected (hit %0d index %0d)",
                 $time, hit, nearest_index);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (hit !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
          errors++;
        end
        if (nearest_index !== e.idx) begin
          $display("%0t: index expected %0d actual %0d", $time, e.idx, nearest_index);
          errors++;
        end
        if (distance !== e.tval) begin
          $display("%0t: distance expected %h actual %h", $time, e.tval, distance);
          errors++;
        end
        if (weight_a !== e.w[0]) begin
          $display("%0t: weight_a expected %h actual %h", $time, e.w[0], weight_a);
          errors++;
        end
        if (weight_b !== e.w[1]) begin
          $display("%0t: weight_b expected %h actual %h", $time, e.w[1], weight_b);
          errors++;
        end
        if (weight_c !== e.w[2]) begin
          $display("%0t: weight_c expected %h actual %h", $time, e.w[2], weight_c);
          errors++;
        end
      end
    end
  end

  // Receiver: changing stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = 4000;
      end
      if (mode_cnt == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(16, 200);
      end else begin
        mode_cnt--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = value;
      CFG_ORIGIN_Y: ray_org[1] = value;
      CFG_ORIGIN_Z: ray_org[2] = value;
      CFG_DIR_X:    ray_dir[0] = value;
      CFG_DIR_Y:    ray_dir[1] = value;
      CFG_DIR_Z:    ray_dir[2] = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
  endtask

  task automatic send_tri(input tri_t tr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    a_x <= tr.a[0]; a_y <= tr.a[1]; a_z <= tr.a[2];
    b_x <= tr.b[0]; b_y <= tr.b[1]; b_z <= tr.b[2];
    c_x <= tr.c[0]; c_y <= tr.c[1]; c_z <= tr.c[2];
    last_tri <= tr.last;
    do @(posedge clk); while (!in_ready);
    track_triangle(tr);
    items_sent++;
  endtask

  function automatic tri_t mk_tri(input logic signed [31:0] ax, ay, az, bx, by, bz,
                                  cx, cy, cz, input logic last);
    tri_t tr;
    tr.a[0] = ax; tr.a[1] = ay; tr.a[2] = az;
    tr.b[0] = bx; tr.b[1] = by; tr.b[2] = bz;
    tr.c[0] = cx; tr.c[1] = cy; tr.c[2] = cz;
    tr.last = last;
    return tr;
  endfunction

  // Mostly triangles placed around a point on the ray, some noise and degenerate ones.
  function automatic tri_t rand_tri(input logic last);
    tri_t tr;
    logic signed [31:0] p [3];
    int t0, spread, kind;
    kind = $urandom_range(0, 99);
    t0 = $urandom_range(0, 6);
    for (int k = 0; k < 3; k++) p[k] = ray_org[k] + ray_dir[k] * t0;
    for (int k = 0; k < 3; k++) begin
      if (kind < 8) begin
        tr.a[k] = $urandom(); tr.b[k] = $urandom(); tr.c[k] = $urandom();
      end else begin
        spread = 1 << $urandom_range(8, 18);
        tr.a[k] = p[k] + $urandom_range(0, 2 * spread) - spread;
        tr.b[k] = p[k] + $urandom_range(0, 2 * spread) - spread;
        tr.c[k] = p[k] + $urandom_range(0, 2 * spread) - spread;
      end
    end
    if (kind >= 8 && kind < 12) tr.c = tr.a;
    tr.last = last;
    return tr;
  endfunction

  task automatic send_scene(input int len);
    for (int i = 0; i < len; i++) send_tri(rand_tri(i == len - 1));
  endtask

  task automatic random_ray();
    set_ray($urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 21) - (1 << 20),
            $urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 18) - (1 << 17),
            $urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0, 1 << 18) - (1 << 17));
  endtask

  task automatic test_directed();
    // Default ray from reset: origin zero, pointing down z.
    send_tri(mk_tri(-U, -U, -U, 2 * U, -U, -U, -U, 2 * U, -U, 1));
    send_tri(mk_tri(0, -U, -2 * U, 0, U, -2 * U, U, 0, -2 * U, 1));
    send_tri(mk_tri(0, 0, 0, U, 0, 0, 0, U, 0, 1));
    send_tri(mk_tri(-U, -U, -U, -U, -U, -U, U, U, -U, 0));
    send_tri(mk_tri(0, 0, 0, 0, U, 0, 0, 0, -U, 0));
    send_tri(mk_tri(-U, -U, U, 2 * U, -U, U, -U, 2 * U, U, 1));
    send_tri(mk_tri(-U, -U, -3 * U, 2 * U, -U, -3 * U, -U, 2 * U, -3 * U, 0));
    send_tri(mk_tri(-U, -U, -3 * U, 2 * U, -U, -3 * U, -U, 2 * U, -3 * U, 0));
    send_tri(mk_tri(-U, -U, -2 * U, 2 * U, -U, -2 * U, -U, 2 * U, -2 * U, 0));
    send_tri(mk_tri(-U, -U, -5 * U, 2 * U, -U, -5 * U, -U, 2 * U, -5 * U, 1));
    send_tri(mk_tri('1 << 31, '1 << 31, '1 << 31, '1 << 31, '1 << 31, '1 << 31,
                    '1 << 31, '1 << 31, '1 << 31, 0));
    send_tri(mk_tri(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh7FFFFFFF, 1));
    send_tri(mk_tri(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                    32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7FFFFFFF, 1));
    idle_input();
    drain();
    // A tiny direction drives t into saturation; the first saturated hit is kept.
    write_reg(CFG_DIR_Z, -32'sd1);
    send_tri(mk_tri(-U, -U, 32'shC0000000, 2 * U, -U, 32'shC0000000, -U, 2 * U,
                    32'shC0000000, 0));
    send_tri(mk_tri(-U, -U, 32'sh80000000, 2 * U, -U, 32'sh80000000, -U, 2 * U,
                    32'sh80000000, 1));
    idle_input();
    drain();
  endtask

  task automatic test_register_extremes();
    set_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000);
    for (int i = 0; i < 6; i++) send_scene($urandom_range(1, 4));
    idle_input();
    drain();
    set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF);
    for (int i = 0; i < 6; i++) send_scene($urandom_range(1, 4));
    idle_input();
    drain();
    set_ray(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_scene($urandom_range(1, 4));
    idle_input();
    drain();
    set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    for (int i = 0; i < 4; i++) send_scene($urandom_range(1, 4));
    idle_input();
    drain();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 12; i++) send_scene($urandom_range(1, 4));
    idle_input();
    drain();
  endtask

  task automatic test_pause();
    send_scene(5);
    idle_input();
    while (pending_hits.size() != 0) @(posedge clk);
    send_scene(5);
    idle_input();
    drain();
  endtask

  task automatic test_random();
    random_ray();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        idle_input();
        drain();
        random_ray();
      end
      send_scene($urandom_range(1, 6));
    end
    idle_input();
    drain();
  endtask

  initial begin
    ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
    ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = -U;
    clear_search();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_pause();
    test_random();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
